FILE: src/gccd_pkg.sv
package gccd_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int ENTRY_SLOTS = 2 * MAX_EDGES;
    localparam int NW = $clog2(MAX_NODES);      // vertex bits
    localparam int EW = $clog2(ENTRY_SLOTS);    // entry index bits
    localparam int SW = NW + 1;                 // stack depth / scan bits

    typedef enum logic [1:0] {
        FN_ADD   = 2'd0,
        FN_PULL  = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_FULL    = 3'd2,
        ST_DONE    = 3'd3,
        ST_WALKING = 3'd4
    } status_t;

endpackage

FILE: src/graph_connected_components_dfs_core.sv
// Connected components by depth-first walk.
//
// Input words (s_*): tuser carries func (add edge, pull, clear); tdata carries
// node_a and node_b. One result word (m_*) is returned for every input word:
// tuser = status, tdata = vertex, component index, new-component flag.
// node_count is written through cfg_we/cfg_wdata; the user must do so only while
// the core is idle, which the core itself does not enforce.
// One word is worked on at a time; s_tready is high only while idle. A
// small sequencer drives single-port memories (visited map, list heads and
// tails, edge entries, walk stack) with registered reads:
//   add edge   : two list appends (read the list, write the entry, link the old tail)
//   pull       : pops exhausted frames and skips visited neighbours and visited
//                roots until a new root or an unstacked neighbour is pushed and
//                returned; once the walk is finished, ST_DONE is returned
//   clear      : one visited/list entry cleared per cycle
// After reset the same clearing pass runs before s_tready rises.
// Results sit in an output register; a stalled receiver holds it, and a new
// word may be accepted meanwhile, but its result waits until the previous
// one is taken.
module graph_connected_components_dfs_core
    import gccd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,   // node_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // [9:0] node_a, [19:10] node_b, zero pad
    input  logic [1:0]  s_tuser,     // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [9:0] vertex, [19:10] component_index,
                                     // [20] new_component, zero pad
    output logic [2:0]  m_tuser      // [2:0] status
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_A1, S_A2, S_A3, S_TOP, S_LD, S_CHK, S_ENT, S_VIS,
        S_PUSH, S_RCHK, S_RVIS, S_EMIT
    } state_t;

    localparam int LW = 2 * EW + 1;   // list word: valid, head, tail
    localparam int KW = NW + 1 + EW;  // stack word: vertex, pos valid, pos

    // Memories
    logic          vis_mem [MAX_NODES];
    logic [LW-1:0] lst_mem [MAX_NODES];
    logic [NW-1:0] enb_mem [ENTRY_SLOTS];
    logic [EW:0]   enx_mem [ENTRY_SLOTS];
    logic [KW-1:0] stk_mem [MAX_NODES];

    logic          vis_q;
    logic [LW-1:0] lst_q;
    logic [NW-1:0] enb_q;
    logic [EW:0]   enx_q;
    logic [KW-1:0] stk_q;

    logic          vis_we, lst_we, enb_we, enx_we, stk_we;
    logic          vis_wd;
    logic [NW-1:0] vis_wa, vis_ra, lst_wa, lst_ra, stk_wa, stk_ra;
    logic [LW-1:0] lst_wd;
    logic [EW-1:0] enb_wa, enx_wa, ent_ra;
    logic [NW-1:0] enb_wd;
    logic [EW:0]   enx_wd;
    logic [KW-1:0] stk_wd;

    // Control state
    state_t        state_reg;
    logic [NW-1:0] node_count_reg;
    logic [NW-1:0] a_reg, b_reg, nb_reg, fr_vtx_reg;
    logic          pass_reg, fr_pv_reg, is_root_reg, tv_reg, clr_emit_reg, walking_reg;
    logic [EW-1:0] fr_pos_reg, tail_reg, e_reg;
    logic [EW:0]   used_reg;
    logic [SW-1:0] sd_reg, root_reg, cc_reg;
    logic [NW-1:0] clr_cnt_reg;
    status_t       res_status_reg;
    logic [NW-1:0] res_vtx_reg, res_comp_reg;
    logic          res_new_reg;
    logic          m_valid_reg;
    logic [23:0]   m_data_reg;
    logic [2:0]    m_user_reg;

    logic [NW-1:0] in_a, in_b, own, nbr, sd_top;
    logic          a_ok, b_ok;

    assign in_a   = s_tdata[NW-1:0];
    assign in_b   = s_tdata[2*NW-1:NW];
    assign a_ok   = (in_a != '0) && (in_a <= node_count_reg);
    assign b_ok   = (in_b != '0) && (in_b <= node_count_reg);
    assign own    = pass_reg ? b_reg : a_reg;
    assign nbr    = pass_reg ? a_reg : b_reg;
    assign sd_top = NW'(sd_reg - SW'(1));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // memory port control
    always_comb
    begin
        vis_we = 1'b0; vis_wa = nb_reg; vis_wd = 1'b1; vis_ra = nb_reg;
        lst_we = 1'b0; lst_wa = own; lst_wd = '0; lst_ra = nb_reg;
        enb_we = 1'b0; enb_wa = used_reg[EW-1:0]; enb_wd = nbr;
        enx_we = 1'b0; enx_wa = used_reg[EW-1:0]; enx_wd = '0;
        ent_ra = fr_pos_reg;
        stk_we = 1'b0; stk_wa = sd_top; stk_wd = '0; stk_ra = sd_top;
        case (state_reg)
            S_CLR:
            begin
                vis_we = 1'b1; vis_wa = clr_cnt_reg; vis_wd = 1'b0;
                lst_we = 1'b1; lst_wa = clr_cnt_reg; lst_wd = '0;
            end
            S_A1:
                lst_ra = own;
            S_A2:
            begin
                enb_we = 1'b1;
                enx_we = 1'b1;
                lst_we = 1'b1;
                lst_wd = {1'b1, lst_q[LW-1] ? lst_q[2*EW-1:EW] : used_reg[EW-1:0],
                          used_reg[EW-1:0]};
            end
            S_A3:
            begin
                enx_we = tv_reg; enx_wa = tail_reg; enx_wd = {1'b1, e_reg};
            end
            S_ENT:
            begin
                stk_we = 1'b1;
                stk_wd = {fr_vtx_reg, enx_q};
                vis_ra = enb_q;
            end
            S_VIS:
                vis_we = ~vis_q;
            S_PUSH:
            begin
                stk_we = (sd_reg < SW'(MAX_NODES));
                stk_wa = sd_reg[NW-1:0];
                stk_wd = {nb_reg, lst_q[LW-1], lst_q[2*EW-1:EW]};
            end
            S_RCHK:
                vis_ra = root_reg[NW-1:0];
            S_RVIS:
                vis_we = ~vis_q;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (vis_we) vis_mem[vis_wa] <= vis_wd;
        vis_q <= vis_mem[vis_ra];
    end

    always_ff @(posedge clk)
    begin
        if (lst_we) lst_mem[lst_wa] <= lst_wd;
        lst_q <= lst_mem[lst_ra];
    end

    always_ff @(posedge clk)
    begin
        if (enb_we) enb_mem[enb_wa] <= enb_wd;
        enb_q <= enb_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (enx_we) enx_mem[enx_wa] <= enx_wd;
        enx_q <= enx_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we) stk_mem[stk_wa] <= stk_wd;
        stk_q <= stk_mem[stk_ra];
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            node_count_reg <= NW'(MAX_NODES - 1);
            clr_cnt_reg    <= '0;
            clr_emit_reg   <= 1'b0;
            used_reg       <= '0;
            sd_reg         <= '0;
            root_reg       <= SW'(1);
            cc_reg         <= '0;
            walking_reg    <= 1'b0;
            pass_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            m_user_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                node_count_reg <= cfg_wdata;
            // S_EMIT below owns the valid flag in its own state
            if (m_valid_reg && m_tready && state_reg != S_EMIT)
                m_valid_reg <= 1'b0;

            case (state_reg)
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + NW'(1);
                    if (clr_cnt_reg == NW'(MAX_NODES - 1))
                        state_reg <= clr_emit_reg ? S_EMIT : S_IDLE;
                end
                S_IDLE:
                    if (s_tvalid)
                    begin
                        res_status_reg <= ST_OK;
                        res_vtx_reg    <= '0;
                        res_comp_reg   <= '0;
                        res_new_reg    <= 1'b0;
                        state_reg      <= S_EMIT;
                        case (func_t'(s_tuser))
                            FN_ADD:
                                if (walking_reg)
                                    res_status_reg <= ST_WALKING;
                                else if (!a_ok || !b_ok)
                                    res_status_reg <= ST_RANGE;
                                else if (used_reg > (EW+1)'(ENTRY_SLOTS - 2))
                                    res_status_reg <= ST_FULL;
                                else
                                begin
                                    a_reg     <= in_a;
                                    b_reg     <= in_b;
                                    pass_reg  <= 1'b0;
                                    state_reg <= S_A1;
                                end
                            FN_PULL:
                            begin
                                walking_reg <= 1'b1;
                                state_reg   <= S_TOP;
                            end
                            FN_CLEAR:
                            begin
                                used_reg     <= '0;
                                sd_reg       <= '0;
                                root_reg     <= SW'(1);
                                cc_reg       <= '0;
                                walking_reg  <= 1'b0;
                                clr_cnt_reg  <= '0;
                                clr_emit_reg <= 1'b1;
                                state_reg    <= S_CLR;
                            end
                            default: ;
                        endcase
                    end
                S_A1:
                    state_reg <= S_A2;
                S_A2:
                begin
                    tail_reg  <= lst_q[EW-1:0];
                    tv_reg    <= lst_q[LW-1];
                    e_reg     <= used_reg[EW-1:0];
                    used_reg  <= used_reg + (EW+1)'(1);
                    state_reg <= S_A3;
                end
                S_A3:
                    if (!pass_reg)
                    begin
                        pass_reg  <= 1'b1;
                        state_reg <= S_A1;
                    end
                    else
                        state_reg <= S_EMIT;
                S_TOP:
                    state_reg <= (sd_reg == '0) ? S_RCHK : S_LD;
                S_LD:
                begin
                    {fr_vtx_reg, fr_pv_reg, fr_pos_reg} <= stk_q;
                    state_reg <= S_CHK;
                end
                S_CHK:
                    if (!fr_pv_reg)
                    begin
                        sd_reg    <= sd_reg - SW'(1);
                        state_reg <= S_TOP;
                    end
                    else
                        state_reg <= S_ENT;
                S_ENT:
                begin
                    nb_reg     <= enb_q;
                    fr_pv_reg  <= enx_q[EW];
                    fr_pos_reg <= enx_q[EW-1:0];
                    state_reg  <= S_VIS;
                end
                S_VIS:
                    if (vis_q)
                        state_reg <= S_CHK;
                    else
                    begin
                        is_root_reg <= 1'b0;
                        state_reg   <= S_PUSH;
                    end
                S_PUSH:
                begin
                    if (sd_reg < SW'(MAX_NODES))
                        sd_reg <= sd_reg + SW'(1);
                    res_vtx_reg  <= nb_reg;
                    res_comp_reg <= NW'(cc_reg - SW'(1));
                    res_new_reg  <= is_root_reg;
                    state_reg    <= S_EMIT;
                end
                S_RCHK:
                    if ((root_reg <= {1'b0, node_count_reg}) &&
                        (root_reg < SW'(MAX_NODES)))
                    begin
                        nb_reg    <= root_reg[NW-1:0];
                        root_reg  <= root_reg + SW'(1);
                        state_reg <= S_RVIS;
                    end
                    else
                    begin
                        res_status_reg <= ST_DONE;
                        state_reg      <= S_EMIT;
                    end
                S_RVIS:
                    if (vis_q)
                        state_reg <= S_RCHK;
                    else
                    begin
                        cc_reg      <= cc_reg + SW'(1);
                        is_root_reg <= 1'b1;
                        state_reg   <= S_PUSH;
                    end
                S_EMIT:
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_data_reg   <= {3'b000, res_new_reg, res_comp_reg, res_vtx_reg};
                        m_user_reg   <= res_status_reg;
                        clr_emit_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/gccd_checker.sv
module gccd_checker
    import gccd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // stalled result word stays up
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // one word in work at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held across accepted word");

    // finished walk carries no vertex
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_DONE |-> m_tdata[9:0] == 10'd0)
        else $error("vertex with walk finished");

    // root flag only on a good pull
    a_root: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[20] |-> m_tuser == ST_OK && m_tdata[9:0] != 10'd0)
        else $error("root flag on bad result");

endmodule

bind graph_connected_components_dfs_core gccd_checker u_gccd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
